// File: rtl/ilt_pkg.sv
// ilt_pkg: types, codes and character class functions for the ini line tokenizer
// no dependencies

package ilt_pkg;

    localparam int CHAR_W   = 8;
    localparam int MARK_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CAUSE_W  = 4;
    localparam int POS_W    = 8;
    localparam int PHASE_W  = 4;

    localparam logic [PHASE_W-1:0] PH_INIT          = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_SECTION = 4'd1;
    localparam logic [PHASE_W-1:0] PH_SECTION       = 4'd2;
    localparam logic [PHASE_W-1:0] PH_NAME          = 4'd3;
    localparam logic [PHASE_W-1:0] PH_PRE_EQ        = 4'd4;
    localparam logic [PHASE_W-1:0] PH_POST_EQ       = 4'd5;
    localparam logic [PHASE_W-1:0] PH_VALUE         = 4'd6;
    localparam logic [PHASE_W-1:0] PH_END           = 4'd7;
    localparam logic [PHASE_W-1:0] PH_STOPPED       = 4'd8;

    localparam logic [MARK_W-1:0] MK_NONE       = 3'd0;
    localparam logic [MARK_W-1:0] MK_SEC_BEGIN  = 3'd1;
    localparam logic [MARK_W-1:0] MK_SEC_END    = 3'd2;
    localparam logic [MARK_W-1:0] MK_NAME_BEGIN = 3'd3;
    localparam logic [MARK_W-1:0] MK_NAME_END   = 3'd4;
    localparam logic [MARK_W-1:0] MK_VAL_BEGIN  = 3'd5;
    localparam logic [MARK_W-1:0] MK_VAL_END    = 3'd6;
    localparam logic [MARK_W-1:0] MK_VAL_EMPTY  = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OPEN     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

    localparam logic [CAUSE_W-1:0] ERR_NONE          = 4'd0;
    localparam logic [CAUSE_W-1:0] ERR_LINE_START    = 4'd1;
    localparam logic [CAUSE_W-1:0] ERR_SECTION_START = 4'd2;
    localparam logic [CAUSE_W-1:0] ERR_SECTION_BYTE  = 4'd3;
    localparam logic [CAUSE_W-1:0] ERR_NAME_NEWLINE  = 4'd4;
    localparam logic [CAUSE_W-1:0] ERR_NAME_BYTE     = 4'd5;
    localparam logic [CAUSE_W-1:0] ERR_PRE_NEWLINE   = 4'd6;
    localparam logic [CAUSE_W-1:0] ERR_PRE_BYTE      = 4'd7;
    localparam logic [CAUSE_W-1:0] ERR_POST_BYTE     = 4'd8;
    localparam logic [CAUSE_W-1:0] ERR_VALUE_BYTE    = 4'd9;
    localparam logic [CAUSE_W-1:0] ERR_TRAILING      = 4'd10;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_USCORE  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_HYPHEN  = 8'h2D;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [MARK_W-1:0]   mark;
        logic [STATUS_W-1:0] line_status;
        logic [CAUSE_W-1:0]  error_cause;
        logic                section_found;
        logic                setting_found;
    } t_result;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_ident(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == CH_USCORE) || (c == CH_HYPHEN);
    endfunction

    function automatic logic is_value(input logic [CHAR_W-1:0] c);
        return (c >= 8'h20) && (c <= 8'h7E);
    endfunction

endpackage

// File: rtl/ilt_fsm.sv
// ilt_fsm: line state registers and the per-byte tokenizer step
// depends on ilt_pkg

module ilt_fsm import ilt_pkg::*; #(
    parameter int LINE_LEN = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_kind,
    input  logic [CHAR_W-1:0] i_char,
    output t_result           o_result
);

    localparam int IDX_W = $clog2(LINE_LEN);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(LINE_LEN - 1);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CAUSE_W-1:0] r_err, n_err;
    logic               r_sec, n_sec;
    logic               r_name, n_name;
    logic               r_val, n_val;
    logic [MARK_W-1:0]  mark;
    logic               ok;

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_err   = r_err;
        n_sec   = r_sec;
        n_name  = r_name;
        n_val   = r_val;
        mark    = MK_NONE;
        ok      = 1'b0;

        if (!i_kind) begin
            if (r_phase != PH_STOPPED) begin
                if (i_char == CH_NUL) begin
                    n_phase = PH_STOPPED;
                end else begin
                    case (r_phase)
                        PH_INIT: begin
                            if (i_char == CH_LF) begin
                                n_phase = PH_STOPPED;
                            end else if (is_space(i_char)) begin
                                n_phase = PH_INIT;
                            end else if (i_char == CH_LBRACK) begin
                                n_phase = PH_START_SECTION;
                            end else if (is_ident(i_char)) begin
                                n_phase = PH_NAME;
                                n_name  = 1'b1;
                                mark    = MK_NAME_BEGIN;
                            end else begin
                                n_err   = ERR_LINE_START;
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_START_SECTION: begin
                            if (is_ident(i_char)) begin
                                n_phase = PH_SECTION;
                                n_sec   = 1'b1;
                                mark    = MK_SEC_BEGIN;
                            end else begin
                                n_err   = ERR_SECTION_START;
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_SECTION: begin
                            if (i_char == CH_RBRACK) begin
                                n_phase = PH_END;
                                mark    = MK_SEC_END;
                            end else if (!is_ident(i_char)) begin
                                n_err   = ERR_SECTION_BYTE;
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_NAME: begin
                            if (i_char == CH_LF) begin
                                n_err   = ERR_NAME_NEWLINE;
                                n_phase = PH_STOPPED;
                            end else if (is_space(i_char)) begin
                                n_phase = PH_PRE_EQ;
                                mark    = MK_NAME_END;
                            end else if (i_char == CH_EQUALS) begin
                                n_phase = PH_POST_EQ;
                                mark    = MK_NAME_END;
                            end else if (!is_ident(i_char)) begin
                                n_err   = ERR_NAME_BYTE;
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_PRE_EQ: begin
                            if (i_char == CH_LF) begin
                                n_err   = ERR_PRE_NEWLINE;
                                n_phase = PH_STOPPED;
                            end else if (is_space(i_char)) begin
                                n_phase = PH_PRE_EQ;
                            end else if (i_char == CH_EQUALS) begin
                                n_phase = PH_POST_EQ;
                            end else begin
                                n_err   = ERR_PRE_BYTE;
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_POST_EQ: begin
                            if (i_char == CH_LF) begin
                                n_phase = PH_END;
                                n_val   = 1'b1;
                                mark    = MK_VAL_EMPTY;
                            end else if (is_space(i_char)) begin
                                n_phase = PH_POST_EQ;
                            end else if (is_value(i_char)) begin
                                n_phase = PH_VALUE;
                                n_val   = 1'b1;
                                mark    = MK_VAL_BEGIN;
                            end else begin
                                n_err   = ERR_POST_BYTE;
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_VALUE: begin
                            if (i_char == CH_LF) begin
                                n_phase = PH_END;
                                mark    = MK_VAL_END;
                            end else if (!is_value(i_char)) begin
                                n_err   = ERR_VALUE_BYTE;
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_END: begin
                            if (!is_space(i_char)) begin
                                n_err   = ERR_TRAILING;
                                n_phase = PH_STOPPED;
                            end
                        end
                        default: begin
                            n_phase = PH_STOPPED;
                        end
                    endcase
                end
            end
            if (r_idx != IDX_MAX) begin
                n_idx = r_idx + 1'b1;
            end
        end

        o_result.position = POS_W'(r_idx);
        o_result.mark     = mark;
        if (i_kind) begin
            ok = (r_err == ERR_NONE);
            o_result.line_status   = ok ? ST_ACCEPTED : ST_REJECTED;
            o_result.error_cause   = r_err;
            o_result.section_found = ok && r_sec;
            o_result.setting_found = ok && r_name && r_val;
        end else begin
            ok = (n_err == ERR_NONE);
            if (!ok) begin
                o_result.line_status = ST_REJECTED;
            end else if (n_phase == PH_STOPPED) begin
                o_result.line_status = ST_ACCEPTED;
            end else begin
                o_result.line_status = ST_OPEN;
            end
            o_result.error_cause   = n_err;
            o_result.section_found = ok && n_sec;
            o_result.setting_found = ok && n_name && n_val;
        end

        // end of line returns to the start-of-line state
        if (i_kind) begin
            n_phase = PH_INIT;
            n_idx   = '0;
            n_err   = ERR_NONE;
            n_sec   = 1'b0;
            n_name  = 1'b0;
            n_val   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_INIT;
            r_idx   <= '0;
            r_err   <= ERR_NONE;
            r_sec   <= 1'b0;
            r_name  <= 1'b0;
            r_val   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_err   <= n_err;
            r_sec   <= n_sec;
            r_name  <= n_name;
            r_val   <= n_val;
        end
    end

endmodule

// File: rtl/ini_line_tokenizer.sv
// ini_line_tokenizer: top level with input register, tokenizer step and result register
// depends on ilt_pkg and ilt_fsm
// latency: a result passes through the input register and then the result register before it can be taken
// throughput: one item per cycle while the output is not stalled, set by the tokenizer state update
// the result register parts input and output sides so back-pressure does not stall intake early
// reset: synchronous active-low i_rst_n empties both registers and returns to start of line

module ini_line_tokenizer import ilt_pkg::*; #(
    parameter int LINE_LEN = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // char_code
    input  logic        i_s_axis_tuser,   // kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // position[7:0], mark[10:8], line_status[12:11], error_cause[16:13],
    // section_found[17], setting_found[18], zero fill
    output logic [23:0] o_m_axis_tdata
);

    logic              r_in_valid;
    logic              r_in_kind;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_out_valid;
    t_result           r_out;
    t_result           step_result;
    logic              out_free;
    logic              step;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    ilt_fsm #(
        .LINE_LEN (LINE_LEN)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_kind   (r_in_kind),
        .i_char   (r_in_char),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_kind <= i_s_axis_tuser;
            r_in_char <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out.setting_found, r_out.section_found,
                              r_out.error_cause, r_out.line_status, r_out.mark,
                              r_out.position};

endmodule

// File: bench/tb.sv
// tb: stream-level regression for ini_line_tokenizer, with a per-byte tokenizer model
// in a small checker class and plain tasks that drive lines of bytes
// depends on ilt_pkg and the ini_line_tokenizer rtl

module tb;
    import ilt_pkg::*;

    localparam int LINE_LEN     = 256;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 500;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [MARK_W-1:0]   mark;
        logic [STATUS_W-1:0] status;
        logic [CAUSE_W-1:0]  cause;
        logic                sec;
        logic                setting;
    } t_token;

    class t_token_checker;
        logic [PHASE_W-1:0] phase;
        int                 idx;
        logic [CAUSE_W-1:0] err;
        bit                 sec_seen, name_seen, value_seen;
        t_token             token_queue[$];
        int                 mismatches;
        int                 results;
        int                 lines;
        logic [15:0]        causes_seen;

        function new();
            mismatches  = 0;
            results     = 0;
            lines       = 0;
            causes_seen = '0;
            clear();
        endfunction

        function void clear();
            phase      = PH_INIT;
            idx        = 0;
            err        = ERR_NONE;
            sec_seen   = 0;
            name_seen  = 0;
            value_seen = 0;
        endfunction

        function bit cls_blank(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit cls_word(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z") || c == "_" || c == "-";
        endfunction

        function bit cls_print(logic [7:0] c);
            return c >= 8'h20 && c <= 8'h7E;
        endfunction

        function void reject(logic [CAUSE_W-1:0] cause);
            err   = cause;
            phase = PH_STOPPED;
        endfunction

        function logic [MARK_W-1:0] advance(logic [7:0] c);
            logic [MARK_W-1:0] mk;
            mk = MK_NONE;
            if (phase == PH_STOPPED) return MK_NONE;
            if (c == CH_NUL) begin
                phase = PH_STOPPED;
                return MK_NONE;
            end
            case (phase)
                PH_INIT: begin
                    if (c == CH_LF) phase = PH_STOPPED;
                    else if (cls_blank(c)) ;
                    else if (c == CH_LBRACK) phase = PH_START_SECTION;
                    else if (cls_word(c)) begin
                        phase = PH_NAME; name_seen = 1; mk = MK_NAME_BEGIN;
                    end else reject(ERR_LINE_START);
                end
                PH_START_SECTION: begin
                    if (cls_word(c)) begin
                        phase = PH_SECTION; sec_seen = 1; mk = MK_SEC_BEGIN;
                    end else reject(ERR_SECTION_START);
                end
                PH_SECTION: begin
                    if (c == CH_RBRACK) begin
                        phase = PH_END; mk = MK_SEC_END;
                    end else if (!cls_word(c)) reject(ERR_SECTION_BYTE);
                end
                PH_NAME: begin
                    if (c == CH_LF) reject(ERR_NAME_NEWLINE);
                    else if (cls_blank(c)) begin
                        phase = PH_PRE_EQ; mk = MK_NAME_END;
                    end else if (c == CH_EQUALS) begin
                        phase = PH_POST_EQ; mk = MK_NAME_END;
                    end else if (!cls_word(c)) reject(ERR_NAME_BYTE);
                end
                PH_PRE_EQ: begin
                    if (c == CH_LF) reject(ERR_PRE_NEWLINE);
                    else if (cls_blank(c)) ;
                    else if (c == CH_EQUALS) phase = PH_POST_EQ;
                    else reject(ERR_PRE_BYTE);
                end
                PH_POST_EQ: begin
                    if (c == CH_LF) begin
                        phase = PH_END; value_seen = 1; mk = MK_VAL_EMPTY;
                    end else if (cls_blank(c)) ;
                    else if (cls_print(c)) begin
                        phase = PH_VALUE; value_seen = 1; mk = MK_VAL_BEGIN;
                    end else reject(ERR_POST_BYTE);
                end
                PH_VALUE: begin
                    if (c == CH_LF) begin
                        phase = PH_END; mk = MK_VAL_END;
                    end else if (!cls_print(c)) reject(ERR_VALUE_BYTE);
                end
                PH_END: begin
                    if (!cls_blank(c)) reject(ERR_TRAILING);
                end
                default: phase = PH_STOPPED;
            endcase
            return mk;
        endfunction

        function void note_byte(logic kind, logic [7:0] c);
            t_token t;
            bit     ok;
            t.pos  = idx[POS_W-1:0];
            t.mark = MK_NONE;
            if (!kind) begin
                t.mark = advance(c);
                if (idx < LINE_LEN - 1) idx++;
            end
            ok = (err == ERR_NONE);
            if (!ok) t.status = ST_REJECTED;
            else if (kind || phase == PH_STOPPED) t.status = ST_ACCEPTED;
            else t.status = ST_OPEN;
            t.cause   = err;
            t.sec     = ok && sec_seen;
            t.setting = ok && name_seen && value_seen;
            token_queue.push_back(t);
            if (kind) begin
                causes_seen[err] = 1'b1;
                lines++;
                clear();
            end
        endfunction

        function void flag(string what, t_token e, t_token a);
            if (mismatches < 10)
                $display("mismatch (%s): expected pos %0d mark %0d status %0d cause %0d %b%b, %s",
                         what, e.pos, e.mark, e.status, e.cause, e.sec, e.setting,
                         $sformatf("got pos %0d mark %0d status %0d cause %0d %b%b",
                                   a.pos, a.mark, a.status, a.cause, a.sec, a.setting));
            mismatches++;
        endfunction

        function void check_token(logic [23:0] d);
            t_token a, e;
            a.pos     = d[7:0];
            a.mark    = d[10:8];
            a.status  = d[12:11];
            a.cause   = d[16:13];
            a.sec     = d[17];
            a.setting = d[18];
            results++;
            if (token_queue.size() == 0) begin
                flag("nothing expected", a, a);
                return;
            end
            e = token_queue.pop_front();
            if (a !== e) flag("field", e, a);
        endfunction

        function int pending();
            return token_queue.size();
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;   // char_code
    logic        i_s_axis_tuser  = 1'b0; // kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // position[7:0], mark[10:8], line_status[12:11], error_cause[16:13],
    // section_found[17], setting_found[18], zero fill
    logic [23:0] o_m_axis_tdata;

    t_token_checker tok_chk = new();
    int             send_idle   = 0;
    int             recv_idle   = 0;
    int             hold_left   = 0;
    int             cycle_count = 0;
    int             byte_xfers  = 0;
    int             phase_items = 0;
    logic [7:0]     line_bytes[$];

    ini_line_tokenizer #(.LINE_LEN(LINE_LEN)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                tok_chk.note_byte(i_s_axis_tuser, i_s_axis_tdata);
                byte_xfers++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) tok_chk.check_token(o_m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // long hold-offs take priority over random stalls
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        phase_items++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) send_item(1'b0, line_bytes[i]);
        send_item(1'b1, 8'($urandom_range(0, 255)));
        line_bytes.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endtask

    // drop valid and wait on the clock first so the last input transfer is already noted
    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tok_chk.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        if (r == 62) return CH_USCORE;
        return CH_HYPHEN;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0: return 8'h09;
            1: return 8'h0B;
            2: return 8'h0C;
            3: return 8'h0D;
            default: return 8'h20;
        endcase
    endfunction

    task automatic push_blanks(input int hi);
        repeat ($urandom_range(0, hi)) line_bytes.push_back(blank_char());
    endtask

    task automatic build_line();
        int shape;
        int at;
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
            repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        push_blanks(2);
        if (shape < 60) begin
            repeat ($urandom_range(1, 6)) line_bytes.push_back(word_char());
            push_blanks(2);
            line_bytes.push_back(CH_EQUALS);
            push_blanks(2);
            repeat ($urandom_range(0, 8)) line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else if (shape < 85) begin
            line_bytes.push_back(CH_LBRACK);
            repeat ($urandom_range(1, 6)) line_bytes.push_back(word_char());
            line_bytes.push_back(CH_RBRACK);
            push_blanks(2);
        end
        if ($urandom_range(0, 99) < 85) begin
            line_bytes.push_back(CH_LF);
            push_blanks(1);
        end
        if (line_bytes.size() > 0 && $urandom_range(0, 99) < 20) begin
            at = $urandom_range(0, line_bytes.size() - 1);
            case ($urandom_range(0, 7))
                0: line_bytes[at] = CH_NUL;
                1: line_bytes[at] = CH_LF;
                2: line_bytes[at] = CH_EQUALS;
                default: line_bytes[at] = 8'($urandom_range(0, 255));
            endcase
        end
    endtask

    task automatic send_long_line();
        repeat (300) line_bytes.push_back(word_char());
        push_text(" = v\n");
        send_line();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone newline, section, empty value, zero byte mid-value, bad first byte
        line_bytes.push_back(CH_LF);
        send_line();
        push_text("[Z9]");
        send_line();
        push_text("k=\n");
        send_line();
        push_text(" n = v~");
        line_bytes.push_back(CH_NUL);
        line_bytes.push_back(8'hFF);
        send_line();
        line_bytes.push_back(8'h80);
        send_line();
        wait_drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 31; recv_idle = 82; end
                1: begin send_idle = 82; recv_idle = 31; end
                default: begin send_idle = 0; recv_idle = 0; hold_left = 400; end
            endcase
            phase_items = 0;
            if (ph != 1) send_long_line();
            while (phase_items < PHASE_ITEMS) begin
                build_line();
                send_line();
            end
            wait_drain();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d lines, %0d byte transfers and %0d results in %0d cycles",
                 tok_chk.lines, byte_xfers, tok_chk.results, cycle_count);
        $display("error causes reported at line end: %b, mismatches %0d",
                 tok_chk.causes_seen[10:0], tok_chk.mismatches);
        if (tok_chk.mismatches == 0 && tok_chk.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
